// ----- hw/rtl/rsfs_pkg.sv -----
// Shared types and constants for the checksummed register frame slave.
// No dependencies; used by every module of the block.
package rsfs_pkg;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } rsp_type;

   // one reply as queued between front and back; the checksum is formed on the way out
   typedef struct packed {
      logic [7:0]  addr;
      logic [7:0]  func;
      logic [31:0] word;
      logic [7:0]  code;
   } reply_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [7:0]  FUNC_READ     = 8'h52;
   localparam logic [7:0]  FUNC_WRITE    = 8'h57;
   localparam logic [7:0]  REPLY_FLAG    = 8'h80;
   localparam logic [7:0]  FAIL_CODE     = 8'hFF;
   localparam logic [7:0]  PARAM_VERSION = 8'h00;
   localparam logic [7:0]  PARAM_VOLTAGE = 8'h01;

   localparam logic [7:0]  OWN_ADDR_RESET = 8'h01;
   localparam logic [31:0] VERSION_RESET  = 32'h4083_3333;
   localparam logic [31:0] VOLTAGE_RESET  = 32'h41C4_0000;

   localparam int          FRAME_BYTES   = 7;
   localparam logic [2:0]  POS_CHECKSUM  = 3'd7;

   localparam int          CSR_AW         = 2;
   localparam logic [1:0]  CSR_OWN_ADDR   = 2'd0;

endpackage

// ----- hw/rtl/rsfs_front.sv -----
// Receive side: byte position, running sum, frame store and parameter words.
// Checks each frame and queues a reply descriptor when checksum and address match; depends on rsfs_pkg.
module rsfs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rsfs_pkg::req_type     req_payload,
   input  logic [7:0]            own_address,
   input  rsfs_pkg::q_status_type q_status,
   output logic                  push,
   output rsfs_pkg::reply_type   push_data
);

   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  fb_ff [rsfs_pkg::FRAME_BYTES];
   logic [7:0]  fb_in [rsfs_pkg::FRAME_BYTES];
   logic [31:0] version_ff, version_in;
   logic [31:0] voltage_ff, voltage_in;

   logic        accept;
   logic [2:0]  pos_eff;
   logic [7:0]  b;
   logic [7:0]  func;
   logic [7:0]  code;
   logic [31:0] rx_word;
   logic [31:0] word;
   logic        ok;
   logic        good;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign b         = req_payload.rx_byte;
   assign pos_eff   = req_payload.frame_start ? 3'd0 : pos_ff;

   // decode of the buffered frame, valid when the checksum byte arrives
   assign func    = fb_ff[1];
   assign code    = fb_ff[6];
   assign rx_word = {fb_ff[5], fb_ff[4], fb_ff[3], fb_ff[2]};

   always_comb begin
      ok   = 1'b0;
      word = 32'd0;
      if (func == rsfs_pkg::FUNC_READ) begin
         if (code == rsfs_pkg::PARAM_VERSION) begin
            ok   = 1'b1;
            word = version_ff;
         end else if (code == rsfs_pkg::PARAM_VOLTAGE) begin
            ok   = 1'b1;
            word = voltage_ff;
         end
      end else if (func == rsfs_pkg::FUNC_WRITE) begin
         if (code == rsfs_pkg::PARAM_VERSION || code == rsfs_pkg::PARAM_VOLTAGE) begin
            ok   = 1'b1;
            word = rx_word;
         end
      end
   end

   assign good = (sum_ff == b) && (fb_ff[0] == own_address);

   always_comb begin
      pos_in     = pos_ff;
      sum_in     = sum_ff;
      fb_in      = fb_ff;
      version_in = version_ff;
      voltage_in = voltage_ff;
      push       = 1'b0;
      if (accept) begin
         if (pos_eff != rsfs_pkg::POS_CHECKSUM) begin
            for (int i = 0; i < rsfs_pkg::FRAME_BYTES; i++) begin
               if (pos_eff == 3'(i)) begin
                  fb_in[i] = b;
               end
            end
            sum_in = (pos_eff == 3'd0) ? b : sum_ff + b;
            pos_in = pos_eff + 3'd1;
         end else begin
            pos_in = 3'd0;
            sum_in = 8'd0;
            if (good) begin
               push = 1'b1;
               if (func == rsfs_pkg::FUNC_WRITE) begin
                  if (code == rsfs_pkg::PARAM_VERSION) begin
                     version_in = rx_word;
                  end else if (code == rsfs_pkg::PARAM_VOLTAGE) begin
                     voltage_in = rx_word;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      push_data.addr = own_address;
      push_data.func = func | rsfs_pkg::REPLY_FLAG;
      push_data.word = ok ? word : 32'd0;
      push_data.code = ok ? code : rsfs_pkg::FAIL_CODE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 3'd0;
         sum_ff     <= 8'd0;
         version_ff <= rsfs_pkg::VERSION_RESET;
         voltage_ff <= rsfs_pkg::VOLTAGE_RESET;
      end else begin
         pos_ff     <= pos_in;
         sum_ff     <= sum_in;
         version_ff <= version_in;
         voltage_ff <= voltage_in;
      end
   end

   // frame store has no reset: each entry is written before it is used
   always_ff @(posedge clock) begin
      fb_ff <= fb_in;
   end

endmodule

// ----- hw/rtl/rsfs_queue.sv -----
// Small reply queue between the receive front and the transmit back.
// Depends on rsfs_pkg; depth set by the top level (two or more).
module rsfs_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  rsfs_pkg::reply_type    push_data,
   input  logic                   pop,
   output rsfs_pkg::reply_type    head,
   output rsfs_pkg::q_status_type status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULLN = CW'(DEPTH);

   rsfs_pkg::reply_type mem [DEPTH];
   logic [AW-1:0] wr_ff, wr_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign status.full  = (cnt_ff == FULLN);
   assign status.empty = (cnt_ff == '0);
   assign head         = mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/rsfs_back.sv -----
// Transmit side: serialises one queued reply into eight bytes, adding the checksum.
// Output register decouples the consumer; depends on rsfs_pkg.
module rsfs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  rsfs_pkg::reply_type    head,
   input  rsfs_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsfs_pkg::rsp_type      rsp_payload
);

   rsfs_pkg::reply_type cur_ff, cur_in;
   logic              active_ff, active_in;
   logic [2:0]        idx_ff, idx_in;
   logic [7:0]        sum_ff, sum_in;
   logic              vld_ff, vld_in;
   rsfs_pkg::rsp_type out_ff, out_in;

   rsfs_pkg::reply_type src;
   logic              avail;
   logic              advance;
   logic [7:0]        byte_sel;

   // an idle serialiser reads byte 0 straight from the queue head
   assign src     = active_ff ? cur_ff : head;
   assign avail   = active_ff || !q_status.empty;
   assign advance = avail && (!vld_ff || !rsp_stall);
   assign pop     = advance && !active_ff;

   always_comb begin
      case (idx_ff)
         3'd0:    byte_sel = src.addr;
         3'd1:    byte_sel = src.func;
         3'd2:    byte_sel = src.word[7:0];
         3'd3:    byte_sel = src.word[15:8];
         3'd4:    byte_sel = src.word[23:16];
         3'd5:    byte_sel = src.word[31:24];
         3'd6:    byte_sel = src.code;
         default: byte_sel = sum_ff;
      endcase
   end

   always_comb begin
      cur_in    = cur_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      out_in    = out_ff;
      vld_in    = vld_ff && rsp_stall;
      if (advance) begin
         vld_in           = 1'b1;
         out_in.tx_byte   = byte_sel;
         out_in.last_byte = (idx_ff == rsfs_pkg::POS_CHECKSUM);
         sum_in           = (idx_ff == 3'd0) ? byte_sel : sum_ff + byte_sel;
         if (!active_ff) begin
            cur_in    = head;
            active_in = 1'b1;
         end
         if (idx_ff == rsfs_pkg::POS_CHECKSUM) begin
            active_in = 1'b0;
            idx_in    = 3'd0;
         end else begin
            idx_in    = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= 3'd0;
         vld_ff    <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         vld_ff    <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      sum_ff <= sum_in;
      out_ff <= out_in;
   end

   assign rsp_valid   = vld_ff;
   assign rsp_payload = out_ff;

endmodule

// ----- hw/rtl/checksummed_register_frame_slave_top.sv -----
// Top level of the checksummed register frame slave: CSR port, front, queue, back.
// Depends on rsfs_pkg, rsfs_front, rsfs_queue and rsfs_back.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  rx_byte, frame_start
//   rsp_      out        rsp_valid/rsp_stall  tx_byte, last_byte
//   csr_      in/out     APB psel/penable     own_address at byte 0
//
// One request byte is taken per cycle while the reply queue is not full; the
// frame check runs in the cycle the checksum byte is taken. A reply leaves one
// byte per cycle while rsp_stall is low, passing through the reply queue and
// an output register, so a reply overlaps the next incoming frame. req_stall
// rises only when the reply queue is full. Reset is synchronous; no clearing pass.
module checksummed_register_frame_slave_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  rsfs_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rsfs_pkg::rsp_type            rsp_payload,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [rsfs_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic [7:0]             own_ff;
   logic                   push;
   logic                   pop;
   rsfs_pkg::reply_type    push_data;
   rsfs_pkg::reply_type    head;
   rsfs_pkg::q_status_type q_status;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == rsfs_pkg::CSR_OWN_ADDR) ? {24'd0, own_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= rsfs_pkg::OWN_ADDR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == rsfs_pkg::CSR_OWN_ADDR) begin
         own_ff <= csr_pwdata[7:0];
      end
   end

   rsfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .own_address (own_ff),
      .q_status    (q_status),
      .push        (push),
      .push_data   (push_data)
   );

   rsfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   rsfs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
